[sv/chs_pkg.sv]
// chs_pkg: shared types and codes for the chained hash set
// no dependencies
package chs_pkg;

	localparam int KEY_W              = 31;
	localparam int MODE_W             = 2;
	localparam int STATUS_W           = 2;
	localparam int OUT_BUCKET_W       = 3;
	localparam int DEFAULT_BUCKETS    = 8;
	localparam int DEFAULT_POOL_NODES = 256;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	// result codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
	} req_t;

endpackage

[sv/chs_req_if.sv]
// chs_req_if: request channel (mode, key) with valid/ready
// depends on chs_pkg
interface chs_req_if;
	import chs_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [KEY_W-1:0]    key;

	modport source (output valid, output mode, output key, input ready);
	modport sink   (input valid, input mode, input key, output ready);
endinterface

[sv/chs_rsp_if.sv]
// chs_rsp_if: result channel (status, bucket) with valid/ready
// depends on chs_pkg
interface chs_rsp_if;
	import chs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic [OUT_BUCKET_W-1:0] bucket;

	modport source (output valid, output status, output bucket, input ready);
	modport sink   (input valid, input status, input bucket, output ready);
endinterface

[sv/chs_ram.sv]
// chs_ram: generic single write port, single read port ram, registered read
// no dependencies
module chs_ram #(
	parameter int W = 8,
	parameter int D = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/chs_front.sv]
// chs_front: accepts requests and reduces the key to its bucket, one digit a cycle
// depends on chs_pkg, chs_req_if
module chs_front #(
	parameter int BUCKETS = 8,
	parameter int BKW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	chs_req_if.sink              req,
	input  logic                 hold,
	input  logic                 q_full,
	output logic                 push,
	output chs_pkg::req_t        push_item,
	output logic [BKW-1:0]       push_bucket
);
	import chs_pkg::*;

	localparam int DIG    = 4;
	localparam int DIGITS = (KEY_W + DIG - 1) / DIG;
	localparam int SHW    = DIGITS * DIG;
	localparam int CW     = $clog2(DIGITS + 1);

	logic           busy_q;
	logic [CW-1:0]  cnt_q;
	logic [SHW-1:0] sh_q;
	logic [BKW-1:0] rem_q;
	req_t           item_q;
	logic [BKW:0]   rem_next;
	logic           done;
	logic           accept;

	// four remainder steps on the next key digit
	always_comb begin
		rem_next = {1'b0, rem_q};
		for (int i = 0; i < DIG; i++) begin
			rem_next = {rem_next[BKW-1:0], sh_q[SHW-1-i]};
			if (rem_next >= (BKW+1)'(BUCKETS)) begin
				rem_next = rem_next - (BKW+1)'(BUCKETS);
			end
		end
	end

	assign done        = busy_q && (cnt_q == CW'(DIGITS));
	assign push        = done && !q_full;
	assign push_item   = item_q;
	assign push_bucket = rem_q;
	assign req.ready   = (!busy_q || push) && !hold;
	assign accept      = req.valid && req.ready;

	// request capture and digit sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (push) begin
			busy_q <= 1'b0;
		end else if (busy_q && !done) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// key shifter and running remainder
	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q        <= SHW'(req.key);
			rem_q       <= '0;
			item_q.mode <= req.mode;
			item_q.key  <= req.key;
		end else if (busy_q && !done) begin
			sh_q  <= sh_q << DIG;
			rem_q <= rem_next[BKW-1:0];
		end
	end

endmodule

[sv/chs_queue.sv]
// chs_queue: two-entry queue between front and back
// depends on chs_pkg
module chs_queue #(
	parameter int BKW = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  chs_pkg::req_t  push_item,
	input  logic [BKW-1:0] push_bucket,
	output logic           full,
	output logic           empty,
	input  logic           pop,
	output chs_pkg::req_t  head_item,
	output logic [BKW-1:0] head_bucket
);
	import chs_pkg::*;

	req_t           item_q   [2];
	logic [BKW-1:0] bucket_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;

	assign full        = (cnt_q == 2'd2);
	assign empty       = (cnt_q == 2'd0);
	assign head_item   = item_q[rd_q];
	assign head_bucket = bucket_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_q]   <= push_item;
			bucket_q[wr_q] <= push_bucket;
		end
	end

endmodule

[sv/chs_back.sv]
// chs_back: walks bucket chains in ram and applies lookup, insert and remove
// depends on chs_pkg, chs_rsp_if, chs_ram
module chs_back #(
	parameter int BUCKETS    = 8,
	parameter int POOL_NODES = 256,
	parameter int BKW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	output logic           pop,
	input  chs_pkg::req_t  head_item,
	input  logic [BKW-1:0] head_bucket,
	output logic           clearing,
	chs_rsp_if.source      rsp
);
	import chs_pkg::*;

	localparam int AW = $clog2(POOL_NODES);
	localparam int NW = $clog2(POOL_NODES + 1);
	localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

	localparam logic [2:0] B_IDLE   = 3'd0;
	localparam logic [2:0] B_HEAD   = 3'd1;
	localparam logic [2:0] B_WALK   = 3'd2;
	localparam logic [2:0] B_NODE   = 3'd3;
	localparam logic [2:0] B_DECIDE = 3'd4;
	localparam logic [2:0] B_ALLOC  = 3'd5;
	localparam logic [2:0] B_REM2   = 3'd6;
	localparam logic [2:0] B_DONE   = 3'd7;

	logic [2:0]          state_q;
	logic                clr_q;
	logic [BKW-1:0]      clr_idx_q;
	req_t                op_q;
	logic [BKW-1:0]      bkt_q;
	logic [NW-1:0]       head_q;
	logic [NW-1:0]       cur_q;
	logic [NW-1:0]       prev_q;
	logic [NW-1:0]       steps_q;
	logic [NW-1:0]       link_hit_q;
	logic                hit_q;
	logic [NW-1:0]       free_q;
	logic [NW-1:0]       fill_q;
	logic [STATUS_W-1:0] res_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [BKW-1:0]      out_bucket_q;

	logic                hd_we;
	logic [BKW-1:0]      hd_waddr;
	logic [NW-1:0]       hd_wdata;
	logic [BKW-1:0]      hd_raddr;
	logic [NW-1:0]       hd_rdata;
	logic                ky_we;
	logic [KEY_W-1:0]    ky_rdata;
	logic                lk_we;
	logic [AW-1:0]       lk_waddr;
	logic [NW-1:0]       lk_wdata;
	logic [AW-1:0]       nd_raddr;
	logic [NW-1:0]       lk_rdata;
	logic [NW-1:0]       free_next;
	logic                out_free;

	assign clearing = clr_q;
	assign out_free = !out_valid_q || rsp.ready;
	assign pop      = (state_q == B_IDLE) && !q_empty && !clr_q;

	// next free node: nodes at or past the fill mark were never linked, so the next one is free_q + 1
	assign free_next = (free_q >= fill_q) ? (free_q + 1'b1) : lk_rdata;

	// memory port control
	always_comb begin
		hd_we    = 1'b0;
		hd_waddr = bkt_q;
		hd_wdata = NIL;
		hd_raddr = head_bucket;
		ky_we    = 1'b0;
		lk_we    = 1'b0;
		lk_waddr = cur_q[AW-1:0];
		lk_wdata = free_q;
		nd_raddr = cur_q[AW-1:0];
		if (clr_q) begin
			hd_we    = 1'b1;
			hd_waddr = clr_idx_q;
		end
		unique case (state_q)
			B_DECIDE: begin
				nd_raddr = free_q[AW-1:0];
				if (op_q.mode == MODE_REMOVE && hit_q) begin
					if (prev_q != NIL) begin
						lk_we    = 1'b1;
						lk_waddr = prev_q[AW-1:0];
						lk_wdata = link_hit_q;
					end else begin
						hd_we    = 1'b1;
						hd_wdata = link_hit_q;
					end
				end
			end
			B_ALLOC: begin
				ky_we    = 1'b1;
				lk_we    = 1'b1;
				lk_waddr = free_q[AW-1:0];
				lk_wdata = head_q;
				hd_we    = 1'b1;
				hd_wdata = free_q;
			end
			B_REM2: begin
				lk_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	chs_ram #(.W(NW), .D(BUCKETS), .AW(BKW)) u_heads (
		.clk   (clk),
		.we    (hd_we),
		.waddr (hd_waddr),
		.wdata (hd_wdata),
		.raddr (hd_raddr),
		.rdata (hd_rdata)
	);

	chs_ram #(.W(KEY_W), .D(POOL_NODES), .AW(AW)) u_keys (
		.clk   (clk),
		.we    (ky_we),
		.waddr (free_q[AW-1:0]),
		.wdata (op_q.key),
		.raddr (nd_raddr),
		.rdata (ky_rdata)
	);

	chs_ram #(.W(NW), .D(POOL_NODES), .AW(AW)) u_links (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.raddr (nd_raddr),
		.rdata (lk_rdata)
	);

	// bucket head clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == BKW'(BUCKETS - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// chain walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			free_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: load a new result or drop the one taken
			if (state_q == B_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= B_HEAD;
					end
				end
				B_HEAD: begin
					state_q <= B_WALK;
				end
				B_WALK: begin
					if (cur_q >= NIL || steps_q == NIL) begin
						state_q <= B_DECIDE;
					end else begin
						state_q <= B_NODE;
					end
				end
				B_NODE: begin
					if (ky_rdata == op_q.key) begin
						state_q <= B_DECIDE;
					end else begin
						state_q <= B_WALK;
					end
				end
				B_DECIDE: begin
					if (op_q.mode == MODE_INSERT && !hit_q && free_q != NIL) begin
						state_q <= B_ALLOC;
					end else if (op_q.mode == MODE_REMOVE && hit_q) begin
						state_q <= B_REM2;
					end else begin
						state_q <= B_DONE;
					end
				end
				B_ALLOC: begin
					free_q <= free_next;
					if (free_q == fill_q) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= B_DONE;
				end
				B_REM2: begin
					free_q  <= cur_q;
					state_q <= B_DONE;
				end
				B_DONE: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// walk datapath and result code
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				op_q  <= head_item;
				bkt_q <= head_bucket;
				hit_q <= 1'b0;
			end
			B_HEAD: begin
				head_q  <= hd_rdata;
				cur_q   <= hd_rdata;
				prev_q  <= NIL;
				steps_q <= '0;
			end
			B_NODE: begin
				if (ky_rdata == op_q.key) begin
					hit_q      <= 1'b1;
					link_hit_q <= lk_rdata;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= lk_rdata;
					steps_q <= steps_q + 1'b1;
				end
			end
			B_DECIDE: begin
				case (op_q.mode)
					MODE_INSERT: begin
						res_q <= hit_q ? ST_PRESENT : ((free_q == NIL) ? ST_FULL : ST_OK);
					end
					default: begin
						res_q <= hit_q ? ST_OK : ST_ABSENT;
					end
				endcase
			end
			B_DONE: begin
				if (out_free) begin
					out_status_q <= res_q;
					out_bucket_q <= bkt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.bucket = OUT_BUCKET_W'(out_bucket_q);

endmodule

[sv/chained_hash_set.sv]
// Set of non-negative keys kept as a hash table with separate chaining. Each request is a
// lookup, insert or remove; one result (status, low bucket bits) comes back per request,
// in order. The front reduces the key modulo BUCKETS four bits a cycle and overlaps the
// back, which reads the bucket head and then walks the chain node by node on the single
// read port of the node memories, with setup and update states around the walk. After
// reset the block clears the bucket head memory and takes no request until that is done.
// depends on chs_pkg, chs_req_if, chs_rsp_if, chs_front, chs_queue, chs_back
module chained_hash_set #(
	parameter int BUCKETS    = chs_pkg::DEFAULT_BUCKETS,
	parameter int POOL_NODES = chs_pkg::DEFAULT_POOL_NODES
) (
	input  logic      clk,
	input  logic      arst_n,
	chs_req_if.sink   req,
	chs_rsp_if.source rsp
);
	import chs_pkg::*;

	localparam int BKW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	logic           clearing;
	logic           q_full;
	logic           q_empty;
	logic           push;
	logic           pop;
	req_t           push_item;
	req_t           head_item;
	logic [BKW-1:0] push_bucket;
	logic [BKW-1:0] head_bucket;

	chs_front #(.BUCKETS(BUCKETS), .BKW(BKW)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.hold        (clearing),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item),
		.push_bucket (push_bucket)
	);

	chs_queue #(.BKW(BKW)) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_item   (push_item),
		.push_bucket (push_bucket),
		.full        (q_full),
		.empty       (q_empty),
		.pop         (pop),
		.head_item   (head_item),
		.head_bucket (head_bucket)
	);

	chs_back #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES), .BKW(BKW)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.pop         (pop),
		.head_item   (head_item),
		.head_bucket (head_bucket),
		.clearing    (clearing),
		.rsp         (rsp)
	);

endmodule

[sv/chs_checker.sv]
// chs_checker: port-level assertions for the chained hash set, bound to the top level
// depends on chs_pkg and chained_hash_set
module chs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [chs_pkg::STATUS_W-1:0]     out_status,
	input logic [chs_pkg::OUT_BUCKET_W-1:0] out_bucket
);
	import chs_pkg::*;

	logic [2:0] pend_q;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b0, in_valid && in_ready} - {2'b0, out_valid && out_ready};
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_status) && $stable(out_bucket))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result without a pending request");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd5)
		else $error("more requests in flight than the pipeline holds");

endmodule

bind chained_hash_set chs_checker u_chs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_status (rsp.status),
	.out_bucket (rsp.bucket)
);

[bench/chained_hash_set_test.sv]
// chained_hash_set_test: drives lookup/insert/remove requests into the chained hash set
// and checks every result against a behavioral model of the set kept in the bench
// depends on chs_pkg, chs_req_if, chs_rsp_if, chained_hash_set
module chained_hash_set_test;
	timeunit 1ns;
	timeprecision 1ps;
	import chs_pkg::*;

	localparam int NB = DEFAULT_BUCKETS;
	localparam int NP = DEFAULT_POOL_NODES;
	localparam int NIL = NP;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [OUT_BUCKET_W-1:0] bucket;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	chs_req_if req ();
	chs_rsp_if rsp ();

	chained_hash_set #(.BUCKETS(NB), .POOL_NODES(NP)) DUT (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// model state of the set
	int unsigned heads [NB];
	logic [KEY_W-1:0] keys [NP];
	int unsigned links [NP];
	int unsigned free_node;

	req_t pending_reqs [$];
	result_t expected_results [$];
	int mismatches = 0;
	int cycles = 0;
	int long_hold = 0;
	bit sender_hold = 1'b0;
	bit in_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;

	// predict one result and update the model set
	function automatic result_t apply_request(req_t r);
		result_t res;
		int unsigned b, cur, prev, hit, steps;
		b = r.key % NB;
		cur = heads[b];
		prev = NIL;
		hit = NIL;
		steps = 0;
		while (cur < NIL && steps < NP) begin
			if (keys[cur] == r.key) begin
				hit = cur;
				break;
			end
			prev = cur;
			cur = links[cur];
			steps++;
		end
		if (r.mode == MODE_INSERT) begin
			if (hit < NIL) res.status = ST_PRESENT;
			else if (free_node >= NIL) res.status = ST_FULL;
			else begin
				cur = free_node;
				free_node = links[cur];
				keys[cur] = r.key;
				links[cur] = heads[b];
				heads[b] = cur;
				res.status = ST_OK;
			end
		end else if (r.mode == MODE_REMOVE) begin
			if (hit < NIL) begin
				if (prev < NIL) links[prev] = links[hit];
				else heads[b] = links[hit];
				links[hit] = free_node;
				free_node = hit;
				res.status = ST_OK;
			end else res.status = ST_ABSENT;
		end else begin
			res.status = (hit < NIL) ? ST_OK : ST_ABSENT;
		end
		res.bucket = b[OUT_BUCKET_W-1:0];
		return res;
	endfunction

	function automatic void add_request(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k);
		req_t r;
		r.mode = m;
		r.key = k;
		pending_reqs.push_back(r);
	endfunction

	// key mostly drawn from a small pool so that hits and chains are common
	function automatic logic [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7) return KEY_W'($urandom_range(0, 300) * (sel < 3 ? 8 : 1));
		if (sel < 8) return KEY_W'({$urandom} & 32'h7fffffff);
		return KEY_W'(32'h7fffffff - $urandom_range(0, 40));
	endfunction

	// driver: bursts with gaps, changes at falling edge, holds a waiting request
	always @(negedge clk) begin
		if (req.valid && !in_taken) begin
			req.valid <= 1'b1;
		end else if (pending_reqs.size() == 0 || sender_hold || !arst_n) begin
			req.valid <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left--;
			req.valid <= 1'b0;
		end else begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 20);
			end
			burst_left--;
			req.valid <= 1'b1;
			req.mode <= pending_reqs[0].mode;
			req.key <= pending_reqs[0].key;
		end
		in_taken = 1'b0;
	end

	// receiver stall pattern plus one long hold-off
	always @(negedge clk) begin
		stall_phase = (stall_phase + 1) % 64;
		if (long_hold > 0) begin
			long_hold--;
			rsp.ready <= 1'b0;
		end else if (stall_phase < 24) rsp.ready <= 1'b1;
		else rsp.ready <= ($urandom_range(0, 3) != 0);
	end

	// monitor: check results and record taken requests at the rising edge
	always @(posedge clk) begin
		cycles++;
		if (rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result status=%0d bucket=%0d",
					rsp.status, rsp.bucket);
			end else begin
				result_t e;
				e = expected_results.pop_front();
				if (e.status !== rsp.status || e.bucket !== rsp.bucket) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected status=%0d bucket=%0d, %s=%0d bucket=%0d",
							e.status, e.bucket, "got status", rsp.status, rsp.bucket);
				end
			end
		end
		if (req.valid && req.ready) begin
			expected_results.push_back(apply_request(pending_reqs.pop_front()));
			in_taken = 1'b1;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int i;
		logic [MODE_W-1:0] m;
		req.valid = 1'b0;
		req.mode = MODE_LOOKUP;
		req.key = '0;
		rsp.ready = 1'b0;
		for (i = 0; i < NB; i++) heads[i] = NIL;
		for (i = 0; i < NP; i++) begin
			keys[i] = '0;
			links[i] = i + 1;
		end
		free_node = 0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: extremes, every op, duplicate, absent, unused mode
		add_request(MODE_LOOKUP, '0);
		add_request(MODE_REMOVE, '0);
		add_request(MODE_INSERT, '0);
		add_request(MODE_INSERT, '0);
		add_request(MODE_LOOKUP, '0);
		add_request(MODE_INSERT, {KEY_W{1'b1}});
		add_request(2'd3, {KEY_W{1'b1}});
		add_request(2'd3, 31'd5);
		add_request(MODE_INSERT, 31'd8);
		add_request(MODE_INSERT, 31'd16);
		add_request(MODE_REMOVE, 31'd8);
		add_request(MODE_LOOKUP, 31'd16);
		add_request(MODE_REMOVE, 31'd0);
		add_request(MODE_REMOVE, {KEY_W{1'b1}});
		add_request(MODE_REMOVE, 31'd16);
		add_request(MODE_LOOKUP, 31'h2aaaaaaa);
		add_request(MODE_LOOKUP, 31'h55555555);

		// fill the pool to full, then duplicate and new inserts into it
		for (i = 0; i < NP + 4; i++) add_request(MODE_INSERT, 31'(i * 3));
		add_request(MODE_INSERT, 31'd3);
		add_request(MODE_INSERT, 31'd1);
		for (i = 0; i < 200; i++) add_request(MODE_REMOVE, 31'(i * 3));

		// long receiver hold-off while the sender keeps offering
		long_hold = 400;
		wait (pending_reqs.size() == 0);

		// pause until everything drains
		sender_hold = 1'b1;
		wait (expected_results.size() == 0);
		repeat (50) @(posedge clk);
		sender_hold = 1'b0;

		// random mix, weighted to inserts
		for (i = 0; i < 1070; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: m = MODE_INSERT;
				4, 5, 6: m = MODE_REMOVE;
				7: m = 2'd3;
				default: m = MODE_LOOKUP;
			endcase
			add_request(m, pick_key());
		end
		wait (pending_reqs.size() == 0);
		wait (expected_results.size() == 0);
		repeat (1200) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
